// ----- sv/phlt_pkg.sv -----
// Shared types and codes of the peer heartbeat liveness table.
`default_nettype none

package phlt_pkg;

    localparam int OP_W      = 3;
    localparam int KIND_W    = 3;
    localparam int SLOT_W    = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_REG_W = 16;

    typedef logic [OP_W-1:0]      t_op;
    typedef logic [KIND_W-1:0]    t_kind;
    typedef logic [SLOT_W-1:0]    t_slot;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    // input operations
    localparam t_op OP_TICK   = 3'd0;
    localparam t_op OP_PING   = 3'd1;
    localparam t_op OP_PONG   = 3'd2;
    localparam t_op OP_APPEND = 3'd3;
    localparam t_op OP_QUERY  = 3'd4;
    localparam t_op OP_CLEAR  = 3'd5;

    // result event kinds
    localparam t_kind EV_OFFLINE    = 3'd0;
    localparam t_kind EV_ONLINE     = 3'd1;
    localparam t_kind EV_SEND_PING  = 3'd2;
    localparam t_kind EV_PONG_REPLY = 3'd3;
    localparam t_kind EV_Q_ONLINE   = 3'd4;
    localparam t_kind EV_Q_OFFLINE  = 3'd5;
    localparam t_kind EV_Q_UNKNOWN  = 3'd6;

    // configuration register indexes
    localparam t_cfg_idx CFG_PING_INTERVAL = 2'd0;
    localparam t_cfg_idx CFG_TIMEOUT       = 2'd1;
    localparam t_cfg_idx CFG_LOCAL_KEY     = 2'd2;

    // reset values of the configuration registers
    localparam logic [CFG_REG_W-1:0] PING_INTERVAL_RST = 16'd1000;
    localparam logic [CFG_REG_W-1:0] TIMEOUT_RST       = 16'd3000;

endpackage

`default_nettype wire

// ----- sv/phlt_ifs.sv -----
// Valid/ready channel interfaces for operation items and event items.
`default_nettype none

interface phlt_in_if #(
    parameter int KEY_W = 64
) ();
    logic               valid;
    logic               ready;
    phlt_pkg::t_op      op;
    logic [KEY_W-1:0]   peer_key;
    logic               has_address;

    modport source (output valid, output op, output peer_key, output has_address,
                    input ready);
    modport sink   (input valid, input op, input peer_key, input has_address,
                    output ready);
endinterface

interface phlt_out_if ();
    logic               valid;
    logic               ready;
    phlt_pkg::t_kind    event_kind;
    phlt_pkg::t_slot    slot;
    logic               last;

    modport source (output valid, output event_kind, output slot, output last,
                    input ready);
    modport sink   (input valid, input event_kind, input slot, input last,
                    output ready);
endinterface

`default_nettype wire

// ----- sv/peer_heartbeat_liveness_table.sv -----
// Peer heartbeat liveness table: keeps up to MAX_PEERS peers (key, address bit and last pong
// time in one single-port RAM, online and heard bits in flip-flops) and turns operation items
// (tick, ping, pong, append, query, clear) into event items on a valid/ready channel; the last
// event of an operation carries last = 1. The single RAM port visits one entry per cycle
// except while an event waits for a full holding stage; a tick scans the stored peers once,
// or twice with a ping round, a pong or query scans them up to the first key match, and
// ping, append and clear need no scan. One event waits in a holding stage until the next
// is known, so the output register and the sink can run while the table scan continues.
`default_nettype none

module peer_heartbeat_liveness_table #(
    parameter int MAX_PEERS = 32,
    parameter int KEY_BITS  = 64,
    parameter int TIME_BITS = 32
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    phlt_in_if.sink                                     i_in,
    phlt_out_if.source                                  o_out,
    input  wire logic                                   i_cfg_we,
    input  wire phlt_pkg::t_cfg_idx                     i_cfg_idx,
    input  wire logic [((KEY_BITS > 16) ? KEY_BITS : 16)-1:0] i_cfg_wdata
);

    localparam int IW = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;
    localparam int CW = $clog2(MAX_PEERS + 1);
    localparam int EW = KEY_BITS + 1 + TIME_BITS;
    localparam int SW = phlt_pkg::SLOT_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_TDUE  = 3'd1;
    localparam logic [2:0] S_PING  = 3'd2;
    localparam logic [2:0] S_DROP  = 3'd3;
    localparam logic [2:0] S_FIND  = 3'd4;
    localparam logic [2:0] S_FLUSH = 3'd5;

    // control state
    logic [2:0]             r_state, n_state;
    logic [CW-1:0]          r_count, n_count;
    logic [TIME_BITS-1:0]   r_time, n_time;
    logic [TIME_BITS-1:0]   r_lastping, n_lastping;
    logic                   r_pinged, n_pinged;
    logic [MAX_PEERS-1:0]   r_online, n_online;
    logic [MAX_PEERS-1:0]   r_heard, n_heard;
    logic [IW-1:0]          r_eidx, n_eidx;
    logic [phlt_pkg::CFG_REG_W-1:0] r_interval, r_timeout;
    logic [KEY_BITS-1:0]    r_local;
    logic                   r_hv;
    logic                   r_ovalid;

    // payload
    logic [KEY_BITS-1:0]    r_key;
    logic                   r_qry;
    phlt_pkg::t_kind        r_hkind, r_okind;
    logic [IW-1:0]          r_hslot;
    phlt_pkg::t_slot        r_oslot;
    logic                   r_olast;

    // RAM port
    logic                   ram_we;
    logic [IW-1:0]          ram_addr;
    logic [EW-1:0]          ram_wdata, ram_rdata;
    logic [KEY_BITS-1:0]    rd_key;
    logic                   rd_addr;
    logic [TIME_BITS-1:0]   rd_time;

    logic                   in_acc, out_free, can_emit, eidx_last, due, stale, need;
    logic                   emit_go, flush_go;
    phlt_pkg::t_kind        emit_kind;
    logic [IW-1:0]          emit_slot, cnt_idx;
    logic [TIME_BITS-1:0]   ping_age, pong_age;
    logic [IW+SW-1:0]       hslot_ext;

    phlt_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_PEERS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    assign rd_time = ram_rdata[TIME_BITS-1:0];
    assign rd_addr = ram_rdata[TIME_BITS];
    assign rd_key  = ram_rdata[TIME_BITS+1 +: KEY_BITS];

    assign i_in.ready = (r_state == S_IDLE);
    assign in_acc     = i_in.valid && (r_state == S_IDLE);
    assign out_free   = !r_ovalid || o_out.ready;
    assign can_emit   = !r_hv || out_free;
    assign eidx_last  = ((CW'(r_eidx) + CW'(1)) == r_count);
    assign cnt_idx    = r_count[IW-1:0];

    // ping round and pong age tests
    assign ping_age = r_time - r_lastping;
    assign due      = !r_pinged || (ping_age >= TIME_BITS'(r_interval));
    assign pong_age = r_time - rd_time;
    assign stale    = r_online[r_eidx] && r_heard[r_eidx] && (pong_age > TIME_BITS'(r_timeout));

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_time     = r_time;
        n_lastping = r_lastping;
        n_pinged   = r_pinged;
        n_online   = r_online;
        n_heard    = r_heard;
        n_eidx     = r_eidx;
        ram_we     = 1'b0;
        ram_addr   = r_eidx;
        ram_wdata  = {rd_key, rd_addr, r_time};
        emit_go    = 1'b0;
        emit_kind  = phlt_pkg::EV_OFFLINE;
        emit_slot  = r_eidx;
        flush_go   = 1'b0;
        need       = 1'b0;
        case (r_state)
            S_IDLE: begin
                n_eidx   = '0;
                ram_addr = (i_in.op == phlt_pkg::OP_APPEND) ? cnt_idx : '0;
                if (in_acc) begin
                    case (i_in.op)
                        phlt_pkg::OP_TICK: begin
                            n_time  = r_time + TIME_BITS'(1);
                            n_state = S_TDUE;
                        end
                        phlt_pkg::OP_PING: begin
                            if (i_in.peer_key != r_local) begin
                                emit_go   = 1'b1;
                                emit_kind = phlt_pkg::EV_PONG_REPLY;
                                emit_slot = '0;
                                n_state   = S_FLUSH;
                            end
                        end
                        phlt_pkg::OP_PONG: begin
                            if (i_in.peer_key != r_local && r_count != '0) begin
                                n_state = S_FIND;
                            end
                        end
                        phlt_pkg::OP_APPEND: begin
                            if (r_count < CW'(MAX_PEERS)) begin
                                ram_we            = 1'b1;
                                ram_wdata         = {i_in.peer_key, i_in.has_address,
                                                     {TIME_BITS{1'b0}}};
                                n_online[cnt_idx] = 1'b0;
                                n_heard[cnt_idx]  = 1'b0;
                                n_count           = r_count + CW'(1);
                            end
                        end
                        phlt_pkg::OP_QUERY: begin
                            if (r_count == '0) begin
                                emit_go   = 1'b1;
                                emit_kind = phlt_pkg::EV_Q_UNKNOWN;
                                emit_slot = '0;
                                n_state   = S_FLUSH;
                            end else begin
                                n_state = S_FIND;
                            end
                        end
                        phlt_pkg::OP_CLEAR: begin
                            n_count  = '0;
                            n_online = '0;
                            n_heard  = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_TDUE: begin
                n_eidx   = '0;
                ram_addr = '0;
                if (due) begin
                    n_lastping = r_time;
                    n_pinged   = 1'b1;
                end
                if (r_count == '0) begin
                    n_state = S_FLUSH;
                end else if (due) begin
                    n_state = S_PING;
                end else begin
                    n_state = S_DROP;
                end
            end
            // ping every addressed peer; stall on a full holding stage
            S_PING: begin
                need = rd_addr;
                if (!(need && !can_emit)) begin
                    emit_go   = need;
                    emit_kind = phlt_pkg::EV_SEND_PING;
                    if (eidx_last) begin
                        n_eidx  = '0;
                        n_state = S_DROP;
                    end else begin
                        n_eidx = r_eidx + IW'(1);
                    end
                    ram_addr = n_eidx;
                end
            end
            // drop peers whose last pong is too old
            S_DROP: begin
                need = stale;
                if (!(need && !can_emit)) begin
                    emit_go   = need;
                    emit_kind = phlt_pkg::EV_OFFLINE;
                    if (need) begin
                        n_online[r_eidx] = 1'b0;
                    end
                    if (eidx_last) begin
                        n_state = S_FLUSH;
                    end else begin
                        n_eidx = r_eidx + IW'(1);
                    end
                    ram_addr = n_eidx;
                end
            end
            // first-match key search for pong and query
            S_FIND: begin
                if (rd_key == r_key) begin
                    if (r_qry) begin
                        emit_go   = 1'b1;
                        emit_kind = r_online[r_eidx] ? phlt_pkg::EV_Q_ONLINE
                                                     : phlt_pkg::EV_Q_OFFLINE;
                        n_state   = S_FLUSH;
                    end else begin
                        ram_we           = 1'b1;
                        n_online[r_eidx] = 1'b1;
                        n_heard[r_eidx]  = 1'b1;
                        if (!r_online[r_eidx]) begin
                            emit_go   = 1'b1;
                            emit_kind = phlt_pkg::EV_ONLINE;
                            n_state   = S_FLUSH;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end
                end else if (eidx_last) begin
                    if (r_qry) begin
                        emit_go   = 1'b1;
                        emit_kind = phlt_pkg::EV_Q_UNKNOWN;
                        emit_slot = '0;
                        n_state   = S_FLUSH;
                    end else begin
                        n_state = S_IDLE;
                    end
                end else begin
                    n_eidx   = r_eidx + IW'(1);
                    ram_addr = n_eidx;
                end
            end
            // push the held event out as the final one
            S_FLUSH: begin
                if (!r_hv) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    flush_go = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_time     <= '0;
            r_lastping <= '0;
            r_pinged   <= 1'b0;
            r_online   <= '0;
            r_heard    <= '0;
            r_eidx     <= '0;
            r_hv       <= 1'b0;
            r_ovalid   <= 1'b0;
            r_interval <= phlt_pkg::PING_INTERVAL_RST;
            r_timeout  <= phlt_pkg::TIMEOUT_RST;
            r_local    <= '0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_time     <= n_time;
            r_lastping <= n_lastping;
            r_pinged   <= n_pinged;
            r_online   <= n_online;
            r_heard    <= n_heard;
            r_eidx     <= n_eidx;
            if (emit_go) begin
                r_hv <= 1'b1;
            end else if (flush_go) begin
                r_hv <= 1'b0;
            end
            if ((emit_go && r_hv) || flush_go) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    phlt_pkg::CFG_PING_INTERVAL:
                        r_interval <= i_cfg_wdata[phlt_pkg::CFG_REG_W-1:0];
                    phlt_pkg::CFG_TIMEOUT:
                        r_timeout <= i_cfg_wdata[phlt_pkg::CFG_REG_W-1:0];
                    phlt_pkg::CFG_LOCAL_KEY:
                        r_local <= i_cfg_wdata[KEY_BITS-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    assign hslot_ext = {{SW{1'b0}}, r_hslot};

    // payload registers: latched key, holding stage, output stage
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_key <= i_in.peer_key;
            r_qry <= (i_in.op == phlt_pkg::OP_QUERY);
        end
        if (emit_go) begin
            r_hkind <= emit_kind;
            r_hslot <= emit_slot;
        end
        if ((emit_go && r_hv) || flush_go) begin
            r_okind <= r_hkind;
            r_oslot <= hslot_ext[SW-1:0];
            r_olast <= flush_go;
        end
    end

    assign o_out.valid      = r_ovalid;
    assign o_out.event_kind = r_okind;
    assign o_out.slot       = r_oslot;
    assign o_out.last       = r_olast;

endmodule

`default_nettype wire

// ----- sv/phlt_ram.sv -----
// Generic single-port RAM with registered read data (read-first).
`default_nettype none

module phlt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                                       i_clk,
    input  wire logic                                       i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]                           i_wdata,
    output logic      [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

`default_nettype wire

// ----- sv/phlt_checker.sv -----
// Port-level checks of the liveness table, bound to the top level.
`default_nettype none

module phlt_checker (
    input wire logic            i_clk,
    input wire logic            i_rst_n,
    input wire logic            i_in_valid,
    input wire logic            i_in_ready,
    input wire phlt_pkg::t_op   i_in_op,
    input wire logic            i_out_valid,
    input wire logic            i_out_ready,
    input wire phlt_pkg::t_kind i_out_kind,
    input wire phlt_pkg::t_slot i_out_slot,
    input wire logic            i_out_last
);

    // a waiting event item holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_kind) && $stable(i_out_slot) && $stable(i_out_last))
        else $error("event item changed while stalled");

    // a tick always keeps the sequencer busy, so the next item must wait
    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_op == phlt_pkg::OP_TICK |=> !i_in_ready)
        else $error("tick accepted without a table scan");

    // a query always yields an answer, so the next item must wait
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_op == phlt_pkg::OP_QUERY |=> !i_in_ready)
        else $error("query accepted without an answer pending");

    // pong replies and unknown answers concern no slot
    a_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_kind == phlt_pkg::EV_PONG_REPLY ||
                        i_out_kind == phlt_pkg::EV_Q_UNKNOWN) |-> i_out_slot == '0)
        else $error("slot set on a slotless event");

    // query, online and pong-reply events are always alone and thus final
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_kind == phlt_pkg::EV_PONG_REPLY ||
                        i_out_kind == phlt_pkg::EV_ONLINE ||
                        i_out_kind == phlt_pkg::EV_Q_ONLINE ||
                        i_out_kind == phlt_pkg::EV_Q_OFFLINE ||
                        i_out_kind == phlt_pkg::EV_Q_UNKNOWN) |-> i_out_last)
        else $error("single-event operation without last flag");

endmodule

bind peer_heartbeat_liveness_table phlt_checker u_phlt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_op     (i_in.op),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_kind  (o_out.event_kind),
    .i_out_slot  (o_out.slot),
    .i_out_last  (o_out.last)
);

`default_nettype wire
